// ===== rtl/rk4_pkg.sv =====
`timescale 1ns / 1ps

package rk4_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 24;
  localparam int COEF_W    = 31;
  localparam int PROD_W    = 64;
  localparam int SUM_W     = 35;
  localparam int SUM_LO_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam int QW         = 60 - FRAC_BITS;
  localparam int OFF_SHIFT  = QW - 1;
  localparam int DIV_DIGITS = 8;
  localparam int DIV_W      = ((QW + 1 + DIV_DIGITS - 1) / DIV_DIGITS) * DIV_DIGITS;
  localparam int DIV_STEPS  = DIV_W / DIV_DIGITS;
  localparam int DIV_CNT_W  = (DIV_STEPS > 2) ? $clog2(DIV_STEPS) : 1;

  localparam longint ONE_FX = longint'(1) << FRAC_BITS;

  localparam logic [STEP_W-1:0] STEP_RST  = STEP_W'((ONE_FX + 30) / 60);
  localparam logic [COEF_W-1:0] STIFF_RST = COEF_W'(ONE_FX * 15);
  localparam logic [COEF_W-1:0] DAMP_RST  = COEF_W'((ONE_FX + 5) / 10);

  localparam logic signed [PROD_W-1:0] MAX32    = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] MIN32    = -64'sd2147483648;
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(ONE_FX / 2);
  localparam logic signed [PROD_W-1:0] DIV_HALF = PROD_W'(ONE_FX * 3);
  localparam logic signed [PROD_W-1:0] DIV_OFF  = PROD_W'(longint'(3) << OFF_SHIFT);
  localparam logic signed [PROD_W-1:0] DIV_BIAS = PROD_W'(longint'(1) << OFF_SHIFT);

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EK,
    ST_EB,
    ST_ED,
    ST_PV,
    ST_ML,
    ST_MH,
    ST_MA,
    ST_DV,
    ST_WB,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_KX,
    MUL_BV,
    MUL_VH,
    MUL_PH,
    MUL_SLO,
    MUL_SHI
  } mul_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     full_h;
    logic     init;
    logic     load;
    logic     wr_fk;
    logic     wr_xs;
    logic     wr_vs;
    logic     wr_deriv;
    logic     dbl;
    logic     axis;
    logic     wr_lo;
    logic     wr_div;
    logic     div_step;
    logic     wr_state;
  } dp_cmd_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > MAX32) begin
      r = MAX32[DATA_W-1:0];
    end else if (v < MIN32) begin
      r = MIN32[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + RND_HALF) >>> FRAC_BITS;
    return sat32(t);
  endfunction

endpackage

// ===== rtl/rk4_div3.sv =====
`timescale 1ns / 1ps

module rk4_div3 (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [rk4_pkg::DIV_W-1:0]   dividend,
  output logic [rk4_pkg::DIV_W-1:0]   quotient
);

  logic [rk4_pkg::DIV_W-1:0] dvd_r;
  logic [rk4_pkg::DIV_W-1:0] dvd_nxt;
  logic [1:0]                rem_r;
  logic [1:0]                rem_nxt;

  // long division by three, DIV_DIGITS quotient bits each cycle that step is high
  always_comb begin
    logic [2:0] r3;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    for (int i = 0; i < rk4_pkg::DIV_DIGITS; i++) begin
      r3 = {rem_nxt, dvd_nxt[rk4_pkg::DIV_W-1]};
      dvd_nxt = {dvd_nxt[rk4_pkg::DIV_W-2:0], (r3 >= 3'd3)};
      rem_nxt = (r3 >= 3'd3) ? 2'(r3 - 3'd3) : r3[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = dvd_r;

endmodule

// ===== rtl/rk4_dpath.sv =====
`timescale 1ns / 1ps

module rk4_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rk4_pkg::dp_cmd_t                    cmd,
  input  logic signed [rk4_pkg::DATA_W-1:0]   load_position,
  input  logic signed [rk4_pkg::DATA_W-1:0]   load_velocity,
  input  logic                                cfg_wr_en,
  input  logic [rk4_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rk4_pkg::COEF_W-1:0]          cfg_wr_data,
  output logic signed [rk4_pkg::DATA_W-1:0]   position,
  output logic signed [rk4_pkg::DATA_W-1:0]   velocity
);

  logic [rk4_pkg::STEP_W-1:0]          step_size_r;
  logic [rk4_pkg::COEF_W-1:0]          stiffness_r;
  logic [rk4_pkg::COEF_W-1:0]          damping_r;

  logic signed [rk4_pkg::DATA_W-1:0]   x_r;
  logic signed [rk4_pkg::DATA_W-1:0]   v_r;
  logic signed [rk4_pkg::DATA_W-1:0]   xs_r;
  logic signed [rk4_pkg::DATA_W-1:0]   vs_r;
  logic signed [rk4_pkg::DATA_W-1:0]   pdv_r;
  logic signed [rk4_pkg::DATA_W-1:0]   fk_r;
  logic signed [rk4_pkg::SUM_W-1:0]    sumx_r;
  logic signed [rk4_pkg::SUM_W-1:0]    sumv_r;
  logic signed [rk4_pkg::PROD_W-1:0]   prod_r;
  logic signed [rk4_pkg::PROD_W-1:0]   acc_r;

  logic [rk4_pkg::STEP_W-1:0]          h;
  logic signed [rk4_pkg::DATA_W-1:0]   h_ext;
  logic signed [rk4_pkg::DATA_W-1:0]   dt_ext;
  logic signed [rk4_pkg::SUM_W-1:0]    sum_sel;
  logic signed [rk4_pkg::DATA_W-1:0]   s_lo;
  logic signed [rk4_pkg::DATA_W-1:0]   s_hi;
  logic signed [rk4_pkg::DATA_W-1:0]   op_a;
  logic signed [rk4_pkg::DATA_W-1:0]   op_b;
  logic signed [rk4_pkg::PROD_W-1:0]   prod_nxt;

  logic signed [rk4_pkg::DATA_W-1:0]   rnd;
  logic signed [rk4_pkg::PROD_W-1:0]   rnd64;
  logic signed [rk4_pkg::PROD_W-1:0]   x64;
  logic signed [rk4_pkg::PROD_W-1:0]   v64;
  logic signed [rk4_pkg::PROD_W-1:0]   fk64;
  logic signed [rk4_pkg::DATA_W-1:0]   xs_nxt;
  logic signed [rk4_pkg::DATA_W-1:0]   vs_nxt;
  logic signed [rk4_pkg::DATA_W-1:0]   dv_nxt;
  logic signed [rk4_pkg::SUM_W-1:0]    dx_ext;
  logic signed [rk4_pkg::SUM_W-1:0]    dv_ext;
  logic signed [rk4_pkg::SUM_W-1:0]    sumx_nxt;
  logic signed [rk4_pkg::SUM_W-1:0]    sumv_nxt;

  logic signed [rk4_pkg::PROD_W-1:0]   upd_n;
  logic signed [rk4_pkg::PROD_W-1:0]   upd_q;
  logic signed [rk4_pkg::PROD_W-1:0]   upd_off;
  logic [rk4_pkg::DIV_W-1:0]           quot;
  logic signed [rk4_pkg::PROD_W-1:0]   quot64;
  logic signed [rk4_pkg::PROD_W-1:0]   old64;
  logic signed [rk4_pkg::DATA_W-1:0]   state_nxt;

  assign h      = cmd.full_h ? step_size_r : {1'b0, step_size_r[rk4_pkg::STEP_W-1:1]};
  assign h_ext  = {{(rk4_pkg::DATA_W - rk4_pkg::STEP_W){1'b0}}, h};
  assign dt_ext = {{(rk4_pkg::DATA_W - rk4_pkg::STEP_W){1'b0}}, step_size_r};

  assign sum_sel = cmd.axis ? sumv_r : sumx_r;
  assign s_lo    = {{(rk4_pkg::DATA_W - rk4_pkg::SUM_LO_W){1'b0}},
                    sum_sel[rk4_pkg::SUM_LO_W-1:0]};
  assign s_hi    = {{(rk4_pkg::DATA_W - rk4_pkg::SUM_W + rk4_pkg::SUM_LO_W){sum_sel[rk4_pkg::SUM_W-1]}},
                    sum_sel[rk4_pkg::SUM_W-1:rk4_pkg::SUM_LO_W]};

  always_comb begin
    unique case (cmd.mul_sel)
      rk4_pkg::MUL_KX: begin
        op_a = {1'b0, stiffness_r};
        op_b = xs_r;
      end
      rk4_pkg::MUL_BV: begin
        op_a = {1'b0, damping_r};
        op_b = vs_r;
      end
      rk4_pkg::MUL_VH: begin
        op_a = vs_r;
        op_b = h_ext;
      end
      rk4_pkg::MUL_PH: begin
        op_a = pdv_r;
        op_b = h_ext;
      end
      rk4_pkg::MUL_SLO: begin
        op_a = s_lo;
        op_b = dt_ext;
      end
      rk4_pkg::MUL_SHI: begin
        op_a = s_hi;
        op_b = dt_ext;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_nxt = {{(rk4_pkg::PROD_W - rk4_pkg::DATA_W){op_a[rk4_pkg::DATA_W-1]}}, op_a} *
                    {{(rk4_pkg::PROD_W - rk4_pkg::DATA_W){op_b[rk4_pkg::DATA_W-1]}}, op_b};

  assign rnd   = rk4_pkg::round_sat(prod_r);
  assign rnd64 = {{(rk4_pkg::PROD_W - rk4_pkg::DATA_W){rnd[rk4_pkg::DATA_W-1]}}, rnd};
  assign x64   = {{(rk4_pkg::PROD_W - rk4_pkg::DATA_W){x_r[rk4_pkg::DATA_W-1]}}, x_r};
  assign v64   = {{(rk4_pkg::PROD_W - rk4_pkg::DATA_W){v_r[rk4_pkg::DATA_W-1]}}, v_r};
  assign fk64  = {{(rk4_pkg::PROD_W - rk4_pkg::DATA_W){fk_r[rk4_pkg::DATA_W-1]}}, fk_r};

  assign xs_nxt = rk4_pkg::sat32(x64 + rnd64);
  assign vs_nxt = rk4_pkg::sat32(v64 + rnd64);
  assign dv_nxt = rk4_pkg::sat32(-fk64 - rnd64);

  assign dx_ext   = {{(rk4_pkg::SUM_W - rk4_pkg::DATA_W){vs_r[rk4_pkg::DATA_W-1]}}, vs_r};
  assign dv_ext   = {{(rk4_pkg::SUM_W - rk4_pkg::DATA_W){dv_nxt[rk4_pkg::DATA_W-1]}}, dv_nxt};
  assign sumx_nxt = sumx_r + (cmd.dbl ? (dx_ext <<< 1) : dx_ext);
  assign sumv_nxt = sumv_r + (cmd.dbl ? (dv_ext <<< 1) : dv_ext);

  // S*dt, rounded divide by 6*ONE: floor((n + 3*ONE) / (2*ONE)) then floor-divide by 3
  assign upd_n   = acc_r + (prod_r <<< rk4_pkg::SUM_LO_W);
  assign upd_q   = (upd_n + rk4_pkg::DIV_HALF) >>> (rk4_pkg::FRAC_BITS + 1);
  assign upd_off = upd_q + rk4_pkg::DIV_OFF;

  rk4_div3 u_div3 (
    .clk      (clk),
    .load     (cmd.wr_div),
    .step     (cmd.div_step),
    .dividend (upd_off[rk4_pkg::DIV_W-1:0]),
    .quotient (quot)
  );

  assign quot64    = {{(rk4_pkg::PROD_W - rk4_pkg::DIV_W){1'b0}}, quot};
  assign old64     = cmd.axis ? v64 : x64;
  assign state_nxt = rk4_pkg::sat32(old64 + quot64 - rk4_pkg::DIV_BIAS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= '0;
      v_r         <= '0;
      step_size_r <= rk4_pkg::STEP_RST;
      stiffness_r <= rk4_pkg::STIFF_RST;
      damping_r   <= rk4_pkg::DAMP_RST;
    end else begin
      if (cmd.load) begin
        x_r <= load_position;
        v_r <= load_velocity;
      end else if (cmd.wr_state) begin
        if (cmd.axis) begin
          v_r <= state_nxt;
        end else begin
          x_r <= state_nxt;
        end
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          rk4_pkg::CFG_STEP_SIZE: step_size_r <= cfg_wr_data[rk4_pkg::STEP_W-1:0];
          rk4_pkg::CFG_STIFFNESS: stiffness_r <= cfg_wr_data;
          rk4_pkg::CFG_DAMPING:   damping_r   <= cfg_wr_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.init) begin
      xs_r   <= x_r;
      vs_r   <= v_r;
      sumx_r <= '0;
      sumv_r <= '0;
    end else begin
      if (cmd.wr_xs) begin
        xs_r <= xs_nxt;
      end
      if (cmd.wr_vs) begin
        vs_r <= vs_nxt;
      end
      if (cmd.wr_deriv) begin
        sumx_r <= sumx_nxt;
        sumv_r <= sumv_nxt;
      end
    end
    if (cmd.wr_fk) begin
      fk_r <= rnd;
    end
    if (cmd.wr_deriv) begin
      pdv_r <= dv_nxt;
    end
    if (cmd.wr_lo) begin
      acc_r <= prod_r;
    end
  end

  assign position = x_r;
  assign velocity = v_r;

endmodule

// ===== rtl/rk4_ctrl.sv =====
`timescale 1ns / 1ps

module rk4_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rk4_pkg::dp_cmd_t  cmd
);

  rk4_pkg::state_t              state_r;
  rk4_pkg::state_t              state_nxt;
  logic [1:0]                   stage_r;
  logic [1:0]                   stage_nxt;
  logic [rk4_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [rk4_pkg::DIV_CNT_W-1:0] div_cnt_nxt;
  logic                         axis_r;
  logic                         axis_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rk4_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_op ? rk4_pkg::ST_OUT : rk4_pkg::ST_EK;
        end
      end
      rk4_pkg::ST_EK:  state_nxt = rk4_pkg::ST_EB;
      rk4_pkg::ST_EB:  state_nxt = rk4_pkg::ST_ED;
      rk4_pkg::ST_ED:  state_nxt = (stage_r == 2'd3) ? rk4_pkg::ST_ML : rk4_pkg::ST_PV;
      rk4_pkg::ST_PV:  state_nxt = rk4_pkg::ST_EK;
      rk4_pkg::ST_ML:  state_nxt = rk4_pkg::ST_MH;
      rk4_pkg::ST_MH:  state_nxt = rk4_pkg::ST_MA;
      rk4_pkg::ST_MA:  state_nxt = rk4_pkg::ST_DV;
      rk4_pkg::ST_DV: begin
        if (div_cnt_r == rk4_pkg::DIV_CNT_W'(rk4_pkg::DIV_STEPS - 1)) begin
          state_nxt = rk4_pkg::ST_WB;
        end
      end
      rk4_pkg::ST_WB:  state_nxt = axis_r ? rk4_pkg::ST_OUT : rk4_pkg::ST_ML;
      rk4_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = rk4_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rk4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    stage_nxt   = stage_r;
    div_cnt_nxt = div_cnt_r;
    axis_nxt    = axis_r;
    unique case (state_r)
      rk4_pkg::ST_IDLE: begin
        stage_nxt = '0;
        axis_nxt  = 1'b0;
      end
      rk4_pkg::ST_PV: stage_nxt   = stage_r + 2'd1;
      rk4_pkg::ST_MA: div_cnt_nxt = '0;
      rk4_pkg::ST_DV: div_cnt_nxt = div_cnt_r + 1'b1;
      rk4_pkg::ST_WB: axis_nxt    = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    cmd.axis  = axis_r;
    cmd.mul_sel = rk4_pkg::MUL_KX;
    cmd.full_h  = (stage_r == 2'd2);
    unique case (state_r)
      rk4_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid & in_op;
        cmd.init = in_valid & ~in_op;
      end
      rk4_pkg::ST_EK: begin
        cmd.mul_sel = rk4_pkg::MUL_KX;
        cmd.wr_vs   = (stage_r != 2'd0);
      end
      rk4_pkg::ST_EB: begin
        cmd.mul_sel = rk4_pkg::MUL_BV;
        cmd.wr_fk   = 1'b1;
      end
      rk4_pkg::ST_ED: begin
        cmd.mul_sel  = rk4_pkg::MUL_VH;
        cmd.wr_deriv = 1'b1;
        cmd.dbl      = (stage_r == 2'd1) || (stage_r == 2'd2);
      end
      rk4_pkg::ST_PV: begin
        cmd.mul_sel = rk4_pkg::MUL_PH;
        cmd.wr_xs   = 1'b1;
      end
      rk4_pkg::ST_ML: cmd.mul_sel = rk4_pkg::MUL_SLO;
      rk4_pkg::ST_MH: begin
        cmd.mul_sel = rk4_pkg::MUL_SHI;
        cmd.wr_lo   = 1'b1;
      end
      rk4_pkg::ST_MA:  cmd.wr_div   = 1'b1;
      rk4_pkg::ST_DV:  cmd.div_step = 1'b1;
      rk4_pkg::ST_WB:  cmd.wr_state = 1'b1;
      rk4_pkg::ST_OUT: out_valid    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rk4_pkg::ST_IDLE;
      stage_r   <= '0;
      div_cnt_r <= '0;
      axis_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      stage_r   <= stage_nxt;
      div_cnt_r <= div_cnt_nxt;
      axis_r    <= axis_nxt;
    end
  end

endmodule

// ===== rtl/rk4_damped_spring_step_core.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_op, in_load_position, in_load_velocity
// out      output     out_valid / out_ready  out_position, out_velocity
// cfg      input      cfg_wr_en              cfg_index, cfg_wr_data
//
// A load transaction's result is on out in the cycle after acceptance.
// A step transaction runs the four derivative evaluations on one shared 32x32
// multiplier, then the final update of position and then velocity (the divide by
// three runs 8 bits a cycle), then presents the result on out, all at Q8.24.
// One transaction at a time; out_valid holds until out_ready, then in_ready returns.
// Synchronous reset clears position and velocity and sets the config registers to their defaults.

module rk4_damped_spring_step_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic signed [rk4_pkg::DATA_W-1:0]   in_load_position,
  input  logic signed [rk4_pkg::DATA_W-1:0]   in_load_velocity,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rk4_pkg::DATA_W-1:0]   out_position,
  output logic signed [rk4_pkg::DATA_W-1:0]   out_velocity,
  input  logic                                cfg_wr_en,
  input  logic [rk4_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rk4_pkg::COEF_W-1:0]          cfg_wr_data
);

  rk4_pkg::dp_cmd_t cmd;

  rk4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rk4_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .load_position (in_load_position),
    .load_velocity (in_load_velocity),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .position      (out_position),
    .velocity      (out_velocity)
  );

endmodule

// ===== bench/tb_rk4_damped_spring_step_core.sv =====
`timescale 1ns / 1ps

module tb_rk4_damped_spring_step_core;

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;
  localparam logic [rk4_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam longint Q_ONE    = longint'(1) << 24;
  localparam longint WORD_MAX = 2147483647;
  localparam longint WORD_MIN = -WORD_MAX - 1;
  localparam int     CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic               op;
    logic signed [31:0] load_position;
    logic signed [31:0] load_velocity;
  } spring_item_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
  } spring_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                in_op = OP_STEP;
  logic signed [rk4_pkg::DATA_W-1:0]   in_load_position = '0;
  logic signed [rk4_pkg::DATA_W-1:0]   in_load_velocity = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [rk4_pkg::DATA_W-1:0]   out_position;
  logic signed [rk4_pkg::DATA_W-1:0]   out_velocity;
  logic                                cfg_wr_en = 1'b0;
  logic [rk4_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [rk4_pkg::COEF_W-1:0]          cfg_wr_data = '0;

  spring_item_t   pending_items[$];
  spring_result_t predicted_results[$];

  logic [23:0] step_cfg  = 24'd279620;
  logic [30:0] stiff_cfg = 31'd251658240;
  logic [30:0] damp_cfg  = 31'd1677722;
  longint      spring_pos = 0;
  longint      spring_vel = 0;

  int   mismatches = 0;
  int   cycle_count = 0;
  logic calm = 1'b0;
  int   send_gap = 0;
  int   recv_stall = 0;

  rk4_damped_spring_step_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_load_position (in_load_position),
    .in_load_velocity (in_load_velocity),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_position     (out_position),
    .out_velocity     (out_velocity),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint sat_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint round_div(input longint n, input longint d);
    longint m;
    m = n + d / 2;
    if (m >= 0) return m / d;
    return -((-m + d - 1) / d);
  endfunction

  function automatic longint fx_product(input longint a, input longint b);
    return sat_word(round_div(a * b, Q_ONE));
  endfunction

  function automatic longint spring_accel(input longint x, input longint v);
    return sat_word(-fx_product(longint'(stiff_cfg), x) - fx_product(longint'(damp_cfg), v));
  endfunction

  function automatic void integrate_step();
    longint dt, half, ax, av, bx, bv, cx, cv, dx, dv, xs, vs, sx, sv;
    dt   = longint'(step_cfg);
    half = dt >>> 1;
    ax = spring_vel;
    av = spring_accel(spring_pos, spring_vel);
    xs = sat_word(spring_pos + fx_product(ax, half));
    vs = sat_word(spring_vel + fx_product(av, half));
    bx = vs;
    bv = spring_accel(xs, vs);
    xs = sat_word(spring_pos + fx_product(bx, half));
    vs = sat_word(spring_vel + fx_product(bv, half));
    cx = vs;
    cv = spring_accel(xs, vs);
    xs = sat_word(spring_pos + fx_product(cx, dt));
    vs = sat_word(spring_vel + fx_product(cv, dt));
    dx = vs;
    dv = spring_accel(xs, vs);
    sx = ax + 2 * (bx + cx) + dx;
    sv = av + 2 * (bv + cv) + dv;
    spring_pos = sat_word(spring_pos + round_div(sx * dt, 6 * Q_ONE));
    spring_vel = sat_word(spring_vel + round_div(sv * dt, 6 * Q_ONE));
  endfunction

  function automatic void predict_transaction(input spring_item_t item);
    spring_result_t r;
    if (item.op == OP_LOAD) begin
      spring_pos = longint'(item.load_position);
      spring_vel = longint'(item.load_velocity);
    end else begin
      integrate_step();
    end
    r.position = 32'(spring_pos);
    r.velocity = 32'(spring_vel);
    predicted_results.push_back(r);
  endfunction

  function automatic int pick_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 15);
    if (r < 10) return $urandom_range(0, 3);
    if (r < 14) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] random_word();
    int r;
    r = $urandom_range(0, 7);
    if (r < 4) return int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
    if (r < 6) return $urandom;
    if (r == 6) return ($urandom_range(0, 1) == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return int'($urandom_range(0, 15)) - 8;
  endfunction

  task automatic queue_load(input logic signed [31:0] p, input logic signed [31:0] v);
    spring_item_t item;
    item.op = OP_LOAD;
    item.load_position = p;
    item.load_velocity = v;
    pending_items.push_back(item);
  endtask

  task automatic queue_step();
    spring_item_t item;
    item.op = OP_STEP;
    item.load_position = $urandom;
    item.load_velocity = $urandom;
    pending_items.push_back(item);
  endtask

  task automatic write_reg(input logic [rk4_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rk4_pkg::COEF_W-1:0] data);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    case (idx)
      rk4_pkg::CFG_STEP_SIZE: step_cfg  = data[23:0];
      rk4_pkg::CFG_STIFFNESS: stiff_cfg = data;
      rk4_pkg::CFG_DAMPING:   damp_cfg  = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_random_phase(input int count);
    int n, kind, steps;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        queue_load(random_word(), random_word());
        steps = $urandom_range(1, 10);
        repeat (steps) queue_step();
        n += steps + 1;
      end else if (kind < 9) begin
        steps = $urandom_range(1, 6);
        repeat (steps) queue_step();
        n += steps;
      end else begin
        queue_load($urandom, $urandom);
        n++;
      end
    end
  endtask

  always @(posedge clk) begin
    spring_item_t item;
    logic fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        item.op = in_op;
        item.load_position = in_load_position;
        item.load_velocity = in_load_velocity;
        predict_transaction(item);
      end
      if (!in_valid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item = pending_items.pop_front();
          in_valid         <= 1'b1;
          in_op            <= item.op;
          in_load_position <= item.load_position;
          in_load_velocity <= item.load_velocity;
          send_gap = pick_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    spring_result_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, position %0d velocity %0d",
                   $time, out_position, out_velocity);
        end else begin
          exp_r = predicted_results.pop_front();
          if (out_position !== exp_r.position) begin
            mismatches++;
            $display("%0t: position expected %0d actual %0d",
                     $time, exp_r.position, out_position);
          end
          if (out_velocity !== exp_r.velocity) begin
            mismatches++;
            $display("%0t: velocity expected %0d actual %0d",
                     $time, exp_r.velocity, out_velocity);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        recv_stall = pick_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[7:0] == 8'd0) calm <= ($urandom_range(0, 3) == 0);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // defaults after reset
    queue_step();
    queue_load(32'sh0100_0000, 32'sh0);
    repeat (3) queue_step();
    queue_load(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    queue_step();
    queue_load(32'sh8000_0000, 32'sh8000_0000);
    queue_step();
    queue_load(32'sh7FFF_FFFF, 32'sh8000_0000);
    queue_step();
    queue_load(32'sh8000_0000, 32'sh7FFF_FFFF);
    queue_step();
    queue_load(-32'sh0100_0000, 32'sh0280_0000);
    repeat (2) queue_step();
    queue_load(32'sh0, 32'sh0);
    queue_step();
    drain();

    // all registers at their maximum
    write_reg(rk4_pkg::CFG_STEP_SIZE, 31'h00FF_FFFF);
    write_reg(rk4_pkg::CFG_STIFFNESS, 31'h7FFF_FFFF);
    write_reg(rk4_pkg::CFG_DAMPING,   31'h7FFF_FFFF);
    queue_load(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    queue_step();
    queue_load(32'sh8000_0000, 32'sh8000_0000);
    queue_step();
    queue_load(32'sh0100_0000, 32'sh0100_0000);
    repeat (2) queue_step();
    drain();

    // all registers at zero
    write_reg(rk4_pkg::CFG_STEP_SIZE, 31'h0);
    write_reg(rk4_pkg::CFG_STIFFNESS, 31'h0);
    write_reg(rk4_pkg::CFG_DAMPING,   31'h0);
    queue_load(32'sh0100_0000, -32'sh0100_0000);
    repeat (2) queue_step();
    drain();

    // upper data bits beyond step_size, a stiffness value, then an unmapped index
    write_reg(rk4_pkg::CFG_STEP_SIZE, 31'h5A12_3456);
    write_reg(rk4_pkg::CFG_STIFFNESS, 31'h0A00_0000);
    write_reg(CFG_UNUSED,             31'h7FFF_FFFF);
    queue_load(32'sh0200_0000, 32'sh0);
    repeat (2) queue_step();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 3 == 2) begin
        write_reg(rk4_pkg::CFG_STEP_SIZE, 31'($urandom));
        write_reg(rk4_pkg::CFG_STIFFNESS, 31'($urandom));
        write_reg(rk4_pkg::CFG_DAMPING,   31'($urandom));
      end else begin
        write_reg(rk4_pkg::CFG_STEP_SIZE, 31'($urandom_range(1, 32'h0040_0000)));
        write_reg(rk4_pkg::CFG_STIFFNESS, 31'($urandom_range(0, 32'h6400_0000)));
        write_reg(rk4_pkg::CFG_DAMPING,   31'($urandom_range(0, 32'h1400_0000)));
      end
      run_random_phase(105);
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== rk4_damped_spring_step_core.f =====
rtl/rk4_pkg.sv
rtl/rk4_div3.sv
rtl/rk4_dpath.sv
rtl/rk4_ctrl.sv
rtl/rk4_damped_spring_step_core.sv
bench/tb_rk4_damped_spring_step_core.sv
